FILE: rtl/core/nfst_pkg.sv
// ----------------------------------------------------------------------------
// nfst_pkg: shared definitions for the next-fit slot table
// Action codes, controller states, cell control bundle and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package nfst_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_ROWS_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Configuration port geometry.
  localparam int          ADDR_W           = 2;
  localparam logic [1:0]  ADDR_ROWS_IN_USE = 2'd0;

  // Actions carried by a request beat.
  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_FIRST  = 3'd3,
    ACT_NEXT   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  // Broadcast controls from the controller to every cell of the row.
  typedef struct packed {
    logic load;     // place the search token at the start row
    logic shift;    // move the token one row up
    logic set_hit;  // mark the row holding the token occupied
    logic clr_hit;  // mark the row holding the token free
    logic clr_all;  // free every row
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/nfst_if.sv
// ----------------------------------------------------------------------------
// nfst_if: request and response channels of the next-fit slot table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface nfst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] key;
  logic [31:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface nfst_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] key_out;
  logic [31:0] value_out;
  logic [8:0]  entry_count;

  modport source (output valid, ok, key_out, value_out, entry_count, input ready);
  modport sink   (input valid, ok, key_out, value_out, entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nfst_cell.sv
// ----------------------------------------------------------------------------
// nfst_cell: one row of the slot table
// Holds the row's occupied flag and a search token passed from the row below.
// ----------------------------------------------------------------------------
`default_nettype none

module nfst_cell #(
  parameter int IDX_W = 8,
  parameter int INDEX = 0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  nfst_pkg::cell_ctrl_t     ctrl,
  input  wire  [IDX_W-1:0]         start,
  input  wire                      token_in,
  output logic                     token_out,
  output logic                     free_hit,
  output logic                     used_hit
);

  logic token;
  logic valid;

  // Token: placed by a load at the start row, otherwise handed up the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (ctrl.load) begin
      token <= (start == IDX_W'(INDEX));
    end else if (ctrl.shift) begin
      token <= token_in;
    end
  end

  // Occupied flag: only the row holding the token changes on a hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clr_all) begin
      valid <= 1'b0;
    end else if (token && ctrl.set_hit) begin
      valid <= 1'b1;
    end else if (token && ctrl.clr_hit) begin
      valid <= 1'b0;
    end
  end

  assign token_out = token;
  assign free_hit  = token & ~valid;
  assign used_hit  = token & valid;

endmodule

`default_nettype wire

FILE: rtl/core/nfst_chain.sv
// ----------------------------------------------------------------------------
// nfst_chain: the row of table cells
// Links the cells into a token chain and reports whether the token sits on a
// free or on an occupied row.
// ----------------------------------------------------------------------------
`default_nettype none

module nfst_chain #(
  parameter int ROWS  = 256,
  parameter int IDX_W = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  nfst_pkg::cell_ctrl_t     ctrl,
  input  wire  [IDX_W-1:0]         start,
  output logic                     free_any,
  output logic                     used_any
);

  logic [ROWS-1:0] token;
  logic [ROWS-1:0] free_hit;
  logic [ROWS-1:0] used_hit;

  // Row of cells; row 0 has no neighbour below, a wrap reloads the token.
  for (genvar g = 0; g < ROWS; g++) begin : g_row
    logic link_in;
    if (g == 0) begin : g_first
      assign link_in = 1'b0;
    end else begin : g_rest
      assign link_in = token[g-1];
    end

    nfst_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .start     (start),
      .token_in  (link_in),
      .token_out (token[g]),
      .free_hit  (free_hit[g]),
      .used_hit  (used_hit[g])
    );
  end

  // Only one row holds the token, so a plain OR gives the hit.
  assign free_any = |free_hit;
  assign used_any = |used_hit;

endmodule

`default_nettype wire

FILE: rtl/core/next_fit_slot_table_unit.sv
// ----------------------------------------------------------------------------
// next_fit_slot_table_unit: keyed slot table with next-fit allocation
// Controller, payload memory and configuration register around a row of cells.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        action, key, value
//   rsp       out  valid/ready        ok, key_out, value_out, entry_count
//   apb       in   psel/penable       paddr, pwdata -> prdata (rows_in_use)
//
// An item is accepted, then the search token visits one row per cycle (one row
// for remove and get, up to rows_in_use for add, first and next), then the
// response register is loaded. Clear, undefined and out-of-range requests, and
// adds to a full table, skip the search.
// Reset is synchronous and empties the table at once; no sweep follows.
// A stalled response holds in its register while the next request is taken.
//
`default_nettype none

module next_fit_slot_table_unit #(
  parameter int MAX_ROWS    = nfst_pkg::MAX_ROWS_DEF,
  parameter int VALUE_WIDTH = nfst_pkg::VALUE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [nfst_pkg::ADDR_W-1:0]  paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  nfst_req_if.sink                     req,
  nfst_rsp_if.source                   rsp
);

  localparam int IDX_W   = $clog2(MAX_ROWS);
  localparam int CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int STORE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  nfst_pkg::state_t     state;
  nfst_pkg::state_t     state_next;
  nfst_pkg::action_t    act;
  nfst_pkg::action_t    req_act;
  nfst_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0]   rows_in_use;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   last_row;
  logic               last_valid;
  logic [STORE_W-1:0] val;
  logic               res_ok;
  logic [IDX_W-1:0]   res_key;
  logic               res_rd;

  logic [STORE_W-1:0] mem [MAX_ROWS];
  logic [STORE_W-1:0] mem_q;
  logic               mem_wr;
  logic               mem_rd;

  logic               accept;
  logic               go;
  logic [IDX_W-1:0]   go_start;
  logic [IDX_W-1:0]   start;
  logic [16:0]        next_start;
  logic               free_any;
  logic               used_any;
  logic               hit;
  logic               at_end;
  logic               rsp_load;
  logic               cfg_wr;

  // Configuration register, written only while the table is empty.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == nfst_pkg::ADDR_ROWS_IN_USE);
  assign prdata = (paddr == nfst_pkg::ADDR_ROWS_IN_USE) ? 32'(rows_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CNT_W'(MAX_ROWS);
    end else if (cfg_wr && (count == '0) && (pwdata[8:0] != 9'd0)) begin
      if (32'(pwdata[8:0]) > 32'(MAX_ROWS)) begin
        rows_in_use <= CNT_W'(MAX_ROWS);
      end else begin
        rows_in_use <= CNT_W'(pwdata[8:0]);
      end
    end
  end

  // Request decode: where the token starts, and whether a search is needed.
  assign accept     = req.valid && req.ready;
  assign req_act    = nfst_pkg::action_t'(req.action);
  assign next_start = 17'(req.key) + 17'd1;

  always_comb begin
    go       = 1'b0;
    go_start = '0;
    unique case (req_act)
      nfst_pkg::ACT_ADD: begin
        go = (count < rows_in_use);
        if (last_valid && ((CNT_W'(last_row) + CNT_W'(1)) < rows_in_use)) begin
          go_start = last_row + IDX_W'(1);
        end
      end
      nfst_pkg::ACT_REMOVE, nfst_pkg::ACT_GET: begin
        go       = ({1'b0, req.key} < 17'(rows_in_use));
        go_start = req.key[IDX_W-1:0];
      end
      nfst_pkg::ACT_FIRST: begin
        go = 1'b1;
      end
      nfst_pkg::ACT_NEXT: begin
        go       = (next_start < 17'(rows_in_use));
        go_start = next_start[IDX_W-1:0];
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // Search status for the row under the token.
  assign hit    = (act == nfst_pkg::ACT_ADD) ? free_any : used_any;
  assign at_end = ((CNT_W'(pos) + CNT_W'(1)) == rows_in_use);

  nfst_chain #(
    .ROWS  (MAX_ROWS),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .start    (start),
    .free_any (free_any),
    .used_any (used_any)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      nfst_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = go ? nfst_pkg::ST_PROBE : nfst_pkg::ST_DONE;
        end
      end
      nfst_pkg::ST_PROBE: begin
        unique case (act)
          nfst_pkg::ACT_ADD: begin
            if (hit) begin
              state_next = nfst_pkg::ST_DONE;
            end
          end
          nfst_pkg::ACT_FIRST, nfst_pkg::ACT_NEXT: begin
            if (hit || at_end) begin
              state_next = nfst_pkg::ST_DONE;
            end
          end
          default: begin
            state_next = nfst_pkg::ST_DONE;
          end
        endcase
      end
      nfst_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = nfst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nfst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the controller: cell controls, memory enables, handshakes.
  always_comb begin
    ctrl     = '0;
    start    = go_start;
    mem_wr   = 1'b0;
    mem_rd   = 1'b0;
    rsp_load = 1'b0;
    unique case (state)
      nfst_pkg::ST_IDLE: begin
        ctrl.load    = accept && go;
        ctrl.clr_all = accept && (req_act == nfst_pkg::ACT_CLEAR);
      end
      nfst_pkg::ST_PROBE: begin
        start = '0;
        unique case (act)
          nfst_pkg::ACT_ADD: begin
            if (hit) begin
              ctrl.set_hit = 1'b1;
              mem_wr       = 1'b1;
            end else if (at_end) begin
              ctrl.load = 1'b1;
            end else begin
              ctrl.shift = 1'b1;
            end
          end
          nfst_pkg::ACT_REMOVE: begin
            ctrl.clr_hit = hit;
            mem_rd       = hit;
          end
          nfst_pkg::ACT_GET: begin
            mem_rd = hit;
          end
          nfst_pkg::ACT_FIRST, nfst_pkg::ACT_NEXT: begin
            mem_rd     = hit;
            ctrl.shift = !hit && !at_end;
          end
          default: begin
            mem_rd = 1'b0;
          end
        endcase
      end
      nfst_pkg::ST_DONE: begin
        rsp_load = !rsp.valid || rsp.ready;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == nfst_pkg::ST_IDLE);

  // Payload memory: one write or one registered read a cycle at the token row.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[pos] <= val;
    end
    if (mem_rd) begin
      mem_q <= mem[pos];
    end
  end

  // Item registers and search position.
  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= req_act;
      val     <= req.value[STORE_W-1:0];
      pos     <= go_start;
      res_ok  <= 1'b0;
      res_key <= '0;
      res_rd  <= 1'b0;
    end else if (state == nfst_pkg::ST_PROBE) begin
      if (ctrl.shift) begin
        pos <= pos + IDX_W'(1);
      end else if (ctrl.load) begin
        pos <= '0;
      end
      if (hit) begin
        res_ok <= 1'b1;
        res_rd <= (act != nfst_pkg::ACT_ADD);
        if (act == nfst_pkg::ACT_ADD || act == nfst_pkg::ACT_FIRST ||
            act == nfst_pkg::ACT_NEXT) begin
          res_key <= pos;
        end
      end
    end
  end

  // Occupancy count and the last row handed out by an add.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_valid <= 1'b0;
      last_row   <= '0;
    end else if (ctrl.clr_all) begin
      count      <= '0;
      last_valid <= 1'b0;
      last_row   <= '0;
    end else if (ctrl.set_hit) begin
      count      <= count + CNT_W'(1);
      last_valid <= 1'b1;
      last_row   <= pos;
    end else if (ctrl.clr_hit) begin
      count <= count - CNT_W'(1);
    end
  end

  // Response register: holds a stalled beat while the next item is worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.ok          <= res_ok;
      rsp.key_out     <= 16'(res_key);
      rsp.value_out   <= res_rd ? 32'(mem_q) : 32'd0;
      rsp.entry_count <= 9'(count);
    end
  end

`ifndef SYNTHESIS
  // The table never reports more entries than rows in use.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rows_in_use)
    else $error("entry count exceeds rows in use");

  // The search token never walks past the last row in use.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nfst_pkg::ST_PROBE) |-> (CNT_W'(pos) < rows_in_use))
    else $error("search position beyond rows in use");

  // A clear empties the table by the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == nfst_pkg::ACT_CLEAR)) |=> (count == '0) && !last_valid)
    else $error("clear left entries behind");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the next-fit slot table
// A mirror of the table predicts the response to every accepted request
// beat. Each response beat is checked against the oldest prediction. A
// directed sequence covers the corner cases, and randomised phases follow,
// each with a row count and a pattern of idle and stall cycles.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ROWS        = nfst_pkg::MAX_ROWS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  // Action codes that the block does not define; they must answer empty.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [15:0] key_out;
    logic [31:0] value_out;
    logic [8:0]  entry_count;
  } slot_result_t;

  // Mirror of the slot table, plus the responses it still expects.
  class slot_table_mirror;
    bit   [ROWS-1:0]       row_used;
    logic [ROWS-1:0][31:0] row_payload;
    int unsigned           occupied;
    int unsigned           rows_in_use;
    int unsigned           last_row;
    bit                    last_valid;
    slot_result_t          pending_results[$];
    int                    fail_count;

    function new();
      row_used    = '0;
      row_payload = '0;
      occupied    = 0;
      rows_in_use = ROWS;
      last_row    = 0;
      last_valid  = 1'b0;
      fail_count  = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // The row count only changes while the table is empty; zero is ignored.
    function void write_rows(input logic [31:0] data);
      if (occupied != 0 || data[8:0] == 9'd0) return;
      rows_in_use = (data[8:0] > ROWS) ? ROWS : data[8:0];
    endfunction

    function void report(input string field, input logic [31:0] want,
                         input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        fail_count++;
      end
    endfunction

    function void check_rows(input logic [31:0] got);
      report("rows_in_use", 32'(rows_in_use), got);
    endfunction

    // Work out the response to one accepted request beat.
    function void note_request(input logic [2:0] act, input logic [15:0] k,
                               input logic [31:0] v);
      slot_result_t r;
      int unsigned  start;
      int unsigned  row;
      int unsigned  i;
      bit           placed;
      r      = '0;
      placed = 1'b0;
      case (act)
        nfst_pkg::ACT_ADD: begin
          if (occupied < rows_in_use) begin
            start = (last_valid && last_row < rows_in_use) ? last_row + 1 : 0;
            for (i = 0; i < rows_in_use && !placed; i++) begin
              row = start + i;
              if (row >= rows_in_use) row -= rows_in_use;
              if (!row_used[row]) begin
                row_used[row]    = 1'b1;
                row_payload[row] = v;
                occupied++;
                last_row   = row;
                last_valid = 1'b1;
                placed     = 1'b1;
                r.ok       = 1'b1;
                r.key_out  = 16'(row);
              end
            end
          end
        end
        nfst_pkg::ACT_REMOVE: begin
          if (k < rows_in_use && row_used[k]) begin
            row_used[k] = 1'b0;
            occupied--;
            r.ok        = 1'b1;
            r.value_out = row_payload[k];
          end
        end
        nfst_pkg::ACT_GET: begin
          if (k < rows_in_use && row_used[k]) begin
            r.ok        = 1'b1;
            r.value_out = row_payload[k];
          end
        end
        nfst_pkg::ACT_FIRST, nfst_pkg::ACT_NEXT: begin
          // The start of a next search is one past the key, without wrapping.
          start = (act == nfst_pkg::ACT_FIRST) ? 0 : 32'(k) + 1;
          for (row = start; row < rows_in_use && !placed; row++) begin
            if (row_used[row]) begin
              placed      = 1'b1;
              r.ok        = 1'b1;
              r.key_out   = 16'(row);
              r.value_out = row_payload[row];
            end
          end
        end
        nfst_pkg::ACT_CLEAR: begin
          row_used   = '0;
          occupied   = 0;
          last_row   = 0;
          last_valid = 1'b0;
        end
        default: ;
      endcase
      r.entry_count = 9'(occupied);
      pending_results.push_back(r);
    endfunction

    // Compare one accepted response beat with the oldest prediction.
    function void check_response(input logic ok, input logic [15:0] key_out,
                                 input logic [31:0] value_out,
                                 input logic [8:0] entry_count);
      slot_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: response beat with none expected, ok %0b key %0h value %0h count %0d",
                 $time, ok, key_out, value_out, entry_count);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      report("ok", 32'(want.ok), 32'(ok));
      report("key_out", 32'(want.key_out), 32'(key_out));
      report("value_out", want.value_out, value_out);
      report("entry_count", 32'(want.entry_count), 32'(entry_count));
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [nfst_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  nfst_req_if req_ch ();
  nfst_rsp_if rsp_ch ();

  slot_table_mirror mirror;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_request;
  int               hold_left;
  int               cycle_count;

  next_fit_slot_table_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run takes far longer than the slowest correct one.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Response side: random stalls, plus a long hold-off counted here.
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every response beat as it is accepted.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      mirror.check_response(rsp_ch.ok, rsp_ch.key_out, rsp_ch.value_out,
                            rsp_ch.entry_count);
  end

  // Offer one request beat after a random gap and wait until it is taken.
  task automatic send_item(input logic [2:0] act, input logic [15:0] k,
                           input logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_request(act, k, v);
  endtask

  // Stop offering and wait until every expected response has arrived.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (mirror.rows_in_use + 4) @(posedge clk);
  endtask

  // Write the row count, then read it back.
  task automatic program_rows(input logic [31:0] data);
    for (int pass = 0; pass < 2; pass++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (pass == 0);
      paddr   <= nfst_pkg::ADDR_ROWS_IN_USE;
      pwdata  <= data;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (pass == 0) mirror.write_rows(data);
      else mirror.check_rows(prdata);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // One random phase: empty the table, set the row count, then send traffic.
  task automatic run_phase(input logic [8:0] rows, input int add_pct,
                           input int count, input int s_idle, input int r_stall,
                           input int hold);
    logic [31:0] word;
    logic [2:0]  act;
    logic [15:0] k;
    logic [31:0] v;
    int          roll;
    if (mirror.occupied != 0) send_item(nfst_pkg::ACT_CLEAR, 16'($urandom), $urandom);
    settle();
    word      = $urandom;
    word[8:0] = rows;
    program_rows(word);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    hold_request   = hold;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < add_pct) begin
        act = nfst_pkg::ACT_ADD;
      end else begin
        roll = $urandom_range(99);
        if (roll < 35) act = nfst_pkg::ACT_REMOVE;
        else if (roll < 55) act = nfst_pkg::ACT_GET;
        else if (roll < 65) act = nfst_pkg::ACT_FIRST;
        else if (roll < 92) act = nfst_pkg::ACT_NEXT;
        else if (roll < 96) act = nfst_pkg::ACT_CLEAR;
        else act = $urandom_range(1) ? ACT_SPARE7 : ACT_SPARE6;
      end
      // Mostly keys inside the table, now and then any key at all.
      if ($urandom_range(9) == 0) k = 16'($urandom);
      else k = 16'($urandom_range(mirror.rows_in_use - 1));
      case ($urandom_range(15))
        0:       v = 32'h0;
        1:       v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      send_item(act, k, v);
    end
  endtask

  initial begin
    mirror         = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = nfst_pkg::ACT_GET;
    req_ch.key     = '0;
    req_ch.value   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    cycle_count    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, extreme payloads and keys, and keys past the last row.
    send_item(nfst_pkg::ACT_GET, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_FIRST, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(nfst_pkg::ACT_ADD, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_GET, 16'hFFFF, 32'h0);
    send_item(nfst_pkg::ACT_REMOVE, 16'hFFFF, 32'h0);
    send_item(nfst_pkg::ACT_NEXT, 16'hFFFF, 32'h0);
    send_item(nfst_pkg::ACT_NEXT, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_FIRST, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_GET, 16'h0001, 32'h0);
    send_item(ACT_SPARE6, 16'h5A5A, 32'hA5A5_A5A5);
    send_item(ACT_SPARE7, 16'hA5A5, 32'h5A5A_5A5A);
    // A write with entries present must leave the row count alone.
    settle();
    program_rows(32'd4);
    send_item(nfst_pkg::ACT_REMOVE, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_REMOVE, 16'h0001, 32'h0);
    // Zero after masking is ignored; then a two-row table is filled past full.
    settle();
    program_rows(32'h0000_0200);
    program_rows(32'd2);
    send_item(nfst_pkg::ACT_ADD, 16'h0000, 32'h1234_5678);
    send_item(nfst_pkg::ACT_ADD, 16'h0000, 32'h8765_4321);
    send_item(nfst_pkg::ACT_ADD, 16'h0000, 32'hDEAD_BEEF);
    send_item(nfst_pkg::ACT_NEXT, 16'h0001, 32'h0);
    send_item(nfst_pkg::ACT_REMOVE, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_REMOVE, 16'h0001, 32'h0);
    // The last added key now lies beyond a one-row table: the scan starts at 0.
    settle();
    program_rows(32'd1);
    send_item(nfst_pkg::ACT_ADD, 16'h0000, 32'hCAFE_F00D);
    send_item(nfst_pkg::ACT_GET, 16'h0000, 32'h0);
    send_item(nfst_pkg::ACT_CLEAR, 16'h0000, 32'h0);
    // A count above the table size saturates.
    settle();
    program_rows(32'd511);

    // Random phases: rows, add share, beats, send idle, receive stall, hold.
    run_phase(9'd256, 40, 150, 0, 0, 0);
    run_phase(9'd1, 50, 120, 84, 0, 0);
    run_phase(9'd5, 50, 180, 0, 84, 0);
    run_phase(9'd16, 45, 200, 10, 10, 0);
    run_phase(9'd300, 90, 330, 0, 0, 500);
    run_phase(9'd2, 50, 150, 10, 10, 0);
    run_phase(9'd37, 45, 200, 0, 84, 0);
    run_phase(9'd200, 40, 195, 84, 0, 0);

    settle();
    if (mirror.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
